FILE: hw/rtl/safl_pkg.sv
package safl_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam logic [7:0] TYPE_LOWER_T = 8'h74;
	localparam logic [7:0] TYPE_UPPER_T = 8'h54;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BADTYPE = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [63:0] address;
		logic [7:0]  symbol_type;
		logic [15:0] symbol_id;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] match_id;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [15:0] id;
	} entry_t;

endpackage

FILE: hw/rtl/sorted_address_floor_lookup.sv
// Lookup: a binary search over the sorted table, then the result strobe; the search takes
//   up to log2(TABLE_DEPTH)+1 steps (11 at 1024), one registered table read per step.
// Insert: search as above, then move the m entries above the slot up by one (none when
//   m is 0), then write the new entry. An empty table skips the search. A wrong-type or
//   table-full insert answers in the cycle after it is taken.
// One request at a time; the receiver cannot stall, each result is shown for one cycle.
// Reset clears the entry count and control registers; table contents stay undefined until written.
module sorted_address_floor_lookup import safl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SRCH  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] ri_q;
	logic             rd_more_q;
	logic             pend_s1;
	logic [IDX_W-1:0] wi_s1;
	logic             hit_q;
	logic [15:0]      hit_id_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           rd_entry;

	logic             accept;
	logic             bad_type;
	logic             full;
	logic             cmp_le;
	logic [CNT_W-1:0] nlo;
	logic [CNT_W-1:0] nhi;
	logic [CNT_W-1:0] span;
	logic [CNT_W-1:0] nmid;
	logic             go_on;
	logic             done_d;

	safl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	assign accept   = start && (state_q == S_IDLE);
	assign bad_type = (req.cmd == CMD_INSERT) && (req.symbol_type != TYPE_LOWER_T)
		&& (req.symbol_type != TYPE_UPPER_T);
	assign full     = (req.cmd == CMD_INSERT) && (count_q == CNT_W'(TABLE_DEPTH));

	// upper-bound step on the entry read at mid
	assign cmp_le = rd_entry.addr <= req_q.address;
	assign nlo    = cmp_le ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
	assign nhi    = cmp_le ? hi_q : CNT_W'(mid_q);
	assign span   = nhi - nlo;
	assign nmid   = nlo + (span >> 1);
	assign go_on  = nlo < nhi;

	// strobe a result on flagged requests or empty-table lookups, a finished lookup or a write
	assign done_d = (accept && (bad_type || full || ((count_q == '0) && (req.cmd == CMD_LOOKUP))))
		|| ((state_q == S_SRCH) && !go_on && (req_q.cmd == CMD_LOOKUP))
		|| (state_q == S_WRITE);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rd_entry;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !bad_type && !full && (count_q != '0)) begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(count_q >> 1);
				end
			end
			S_SRCH: begin
				if (go_on) begin
					ram_re    = 1'b1;
					ram_raddr = nmid[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				ram_re    = rd_more_q;
				ram_raddr = ri_q;
				ram_we    = pend_s1;
				ram_waddr = wi_s1;
			end
			S_WRITE: begin
				ram_we         = 1'b1;
				ram_waddr      = pos_q;
				ram_wdata.addr = req_q.address;
				ram_wdata.id   = req_q.symbol_id;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= '0;
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			pos_q     <= '0;
			ri_q      <= '0;
			rd_more_q <= 1'b0;
			pend_s1   <= 1'b0;
			wi_s1     <= '0;
			hit_q     <= 1'b0;
			hit_id_q  <= '0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= req;
						hit_q    <= 1'b0;
						hit_id_q <= '0;
						if (bad_type) begin
							rsp_q <= '{1'b0, 16'h0000, ST_BADTYPE};
						end else if (full) begin
							rsp_q <= '{1'b0, 16'h0000, ST_FULL};
						end else begin
							rsp_q <= '0;
							if (count_q == '0) begin
								if (req.cmd == CMD_INSERT) begin
									pos_q   <= '0;
									state_q <= S_WRITE;
								end
							end else begin
								lo_q    <= '0;
								hi_q    <= count_q;
								mid_q   <= IDX_W'(count_q >> 1);
								state_q <= S_SRCH;
							end
						end
					end
				end
				S_SRCH: begin
					lo_q <= nlo;
					hi_q <= nhi;
					if (cmp_le) begin
						hit_q    <= 1'b1;
						hit_id_q <= rd_entry.id;
					end
					if (go_on) begin
						mid_q <= nmid[IDX_W-1:0];
					end else if (req_q.cmd == CMD_LOOKUP) begin
						rsp_q   <= '{cmp_le | hit_q, cmp_le ? rd_entry.id : hit_id_q, ST_DONE};
						state_q <= S_IDLE;
					end else begin
						pos_q <= nlo[IDX_W-1:0];
						if (nlo < count_q) begin
							ri_q      <= IDX_W'(count_q - CNT_W'(1));
							rd_more_q <= 1'b1;
							pend_s1   <= 1'b0;
							state_q   <= S_SHIFT;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_SHIFT: begin
					// move entries up from the top, one read and one write a cycle
					if (rd_more_q) begin
						pend_s1 <= 1'b1;
						wi_s1   <= ri_q + IDX_W'(1);
						if (ri_q == pos_q) begin
							rd_more_q <= 1'b0;
						end else begin
							ri_q <= ri_q - IDX_W'(1);
						end
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					rsp_q   <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hw/rtl/safl_ram.sv
module safl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/safl_checker.sv
module safl_checker import safl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// no result without a request taken or work finishing
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result strobe without a pending request");

	// wrong type answers on the next cycle
	a_badtype: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.cmd == CMD_INSERT) && (req.symbol_type != TYPE_LOWER_T)
			&& (req.symbol_type != TYPE_UPPER_T))
		|=> (done && (rsp.status == ST_BADTYPE) && !busy))
		else $error("wrong-type insert not flagged");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.status == ST_DONE) || (rsp.status == ST_FULL)
			|| (rsp.status == ST_BADTYPE)))
		else $error("undefined status code");

	a_miss_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.match_id == '0))
		else $error("nonzero id on a miss");

	a_flag_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_DONE)) |-> !rsp.found)
		else $error("flagged insert reports a hit");

endmodule

bind sorted_address_floor_lookup safl_checker u_safl_checker (.*);

FILE: sim/sorted_address_floor_lookup_tb.sv
module sorted_address_floor_lookup_tb;
	import safl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ADDR_MAX = '1;
	localparam logic [7:0] TYPE_ZERO = 8'h00;
	localparam logic [7:0] TYPE_ONES = 8'hFF;
	localparam logic [7:0] TYPE_LOWER_S = 8'h73;
	localparam logic [7:0] TYPE_UPPER_U = 8'h55;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// shadow copy of the sorted symbol table
	logic [63:0] sym_addr[$];
	logic [15:0] sym_id[$];
	rsp_t predicted_answers[$];

	int sender_idle_pct = 0;
	int mismatch_count = 0;

	sorted_address_floor_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// number of entries whose start address is not above key
	function automatic int count_at_or_below(input logic [63:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = sym_addr.size();
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (sym_addr[mid] <= key)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic rsp_t predict_floor_answer(input req_t r);
		rsp_t p;
		int pos;
		p = '0;
		p.status = ST_DONE;
		if (r.cmd == CMD_INSERT) begin
			if (r.symbol_type != TYPE_LOWER_T && r.symbol_type != TYPE_UPPER_T) begin
				p.status = ST_BADTYPE;
			end else if (sym_addr.size() >= TABLE_DEPTH_DEF) begin
				p.status = ST_FULL;
			end else begin
				// equal addresses: new entry goes after them
				pos = count_at_or_below(r.address);
				sym_addr.insert(pos, r.address);
				sym_id.insert(pos, r.symbol_id);
			end
		end else begin
			pos = count_at_or_below(r.address);
			if (pos > 0) begin
				p.found = 1'b1;
				p.match_id = sym_id[pos - 1];
			end
		end
		return p;
	endfunction

	function automatic req_t make_insert(input logic [63:0] a, input logic [7:0] t,
			input logic [15:0] id);
		req_t r;
		r.cmd = CMD_INSERT;
		r.address = a;
		r.symbol_type = t;
		r.symbol_id = id;
		return r;
	endfunction

	function automatic req_t make_lookup(input logic [63:0] a);
		req_t r;
		r.cmd = CMD_LOOKUP;
		r.address = a;
		r.symbol_type = 8'($urandom_range(255));
		r.symbol_id = 16'($urandom_range(65535));
		return r;
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(19))
			0, 1, 2: return 8'($urandom_range(255));
			3, 4, 5, 6, 7, 8, 9, 10: return TYPE_LOWER_T;
			default: return TYPE_UPPER_T;
		endcase
	endfunction

	// four picks in ten land near stored entries, so lookups land on, just below and just above them
	function automatic logic [63:0] pick_address();
		logic [63:0] a;
		int n;
		n = sym_addr.size();
		case ($urandom_range(9))
			0: a = '0;
			1: a = ADDR_MAX;
			2, 3: a = {$urandom, $urandom};
			4: a = 64'($urandom_range(63));
			5: a = 64'($urandom_range(65535)) << $urandom_range(48);
			default: begin
				if (n == 0)
					a = {$urandom, $urandom};
				else
					a = sym_addr[$urandom_range(n - 1)] + 64'($urandom_range(2)) - 64'd1;
			end
		endcase
		return a;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// hold start high across back-to-back requests
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted_answers.insert(predicted_answers.size(), predict_floor_answer(r));
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (predicted_answers.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", rsp));
			end else begin
				want = predicted_answers.pop_front();
				if (rsp.found !== want.found)
					flag_mismatch($sformatf("found %b, want %b", rsp.found, want.found));
				if (rsp.match_id !== want.match_id)
					flag_mismatch($sformatf("match_id %h, want %h", rsp.match_id,
						want.match_id));
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
			end
		end
	end

	task automatic test_directed();
		send_request(make_lookup('0));
		send_request(make_lookup(ADDR_MAX));
		send_request(make_insert(64'd1000, TYPE_ZERO, 16'h1111));
		send_request(make_insert(64'd1000, TYPE_ONES, 16'h2222));
		send_request(make_insert(64'd1000, TYPE_LOWER_S, 16'h3333));
		send_request(make_insert(64'd1000, TYPE_UPPER_U, 16'h4444));
		send_request(make_lookup(64'd1000));
		send_request(make_insert(64'd1000, TYPE_LOWER_T, 16'hFFFF));
		send_request(make_insert(64'd1000, TYPE_UPPER_T, 16'h0001));
		send_request(make_lookup(64'd1000));
		send_request(make_lookup(64'd999));
		send_request(make_insert('0, TYPE_LOWER_T, 16'h0000));
		send_request(make_lookup('0));
		send_request(make_insert(ADDR_MAX, TYPE_UPPER_T, 16'h1234));
		send_request(make_lookup(ADDR_MAX));
		send_request(make_lookup(ADDR_MAX - 64'd1));
		send_request(make_lookup(64'd5000));
		send_request(make_insert(64'd500, TYPE_LOWER_T, 16'hABCD));
		send_request(make_lookup(64'd999));
		send_request(make_lookup(64'd499));
		send_request(make_insert(64'd1000, TYPE_UPPER_T, 16'h00FF));
		send_request(make_lookup(64'd1000));
		send_request(make_insert(64'h8000_0000_0000_0000, TYPE_LOWER_T, 16'h5555));
		send_request(make_lookup(64'h7FFF_FFFF_FFFF_FFFF));
		send_request(make_lookup(64'h8000_0000_0000_0000));
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 62)
				send_request(make_insert(pick_address(), pick_type(),
					16'($urandom_range(65535))));
			else
				send_request(make_lookup(pick_address()));
		end
	endtask

	task automatic test_table_full();
		logic [7:0] t;
		while (sym_addr.size() < TABLE_DEPTH_DEF)
			send_request(make_insert(pick_address(),
				$urandom_range(1) ? TYPE_LOWER_T : TYPE_UPPER_T, 16'($urandom_range(65535))));
		for (int i = 0; i < 60; i++) begin
			case ($urandom_range(4))
				0, 1: begin
					t = $urandom_range(1) ? TYPE_LOWER_T : TYPE_UPPER_T;
					send_request(make_insert(pick_address(), t, 16'($urandom_range(65535))));
				end
				2: send_request(make_insert(pick_address(), TYPE_UPPER_U,
					16'($urandom_range(65535))));
				default: send_request(make_lookup(pick_address()));
			endcase
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		sender_idle_pct = 19;
		test_random_mix(245);
		sender_idle_pct = 86;
		test_random_mix(245);
		sender_idle_pct = 0;
		test_random_mix(245);
		test_table_full();
		start <= 1'b0;
		while (predicted_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
